// ----- rtl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and codes of the piecewise linear interpolator: transaction
// payloads, status codes, and the controller to datapath interface.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_WRITE = 1'b0;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_WIDTH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED  = 2'd2;

  typedef struct packed {
    logic                  opcode;
    logic [SLOT_W-1:0]     point_index;
    logic signed [Q_W-1:0] x_value;
    logic signed [Q_W-1:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] y_result;
    logic [STATUS_W-1:0]   status;
  } result_t;

  typedef struct packed {
    logic capture;
    logic mem_write;
    logic read_first;
    logic search_step;
    logic seg_latch;
    logic mult;
    logic div_step;
    logic write_out;
    logic single_out;
    logic zero_out;
    logic final_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic single;
    logic found;
    logic zero_width;
    logic div_last;
  } dp_status_t;

endpackage

// ----- rtl/pli_ctrl.sv -----
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer of the interpolator: dispatches writes and queries, walks the
// segment search, then runs multiply, divide and final saturation steps.
// ----------------------------------------------------------------------------
module pli_ctrl
  import pli_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SEARCH   = 3'd2;
  localparam logic [2:0] S_MULT     = 3'd3;
  localparam logic [2:0] S_DIV      = 3'd4;
  localparam logic [2:0] S_FINAL    = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.is_write) begin
          cmd_o.mem_write = 1'b1;
          cmd_o.write_out = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.read_first = 1'b1;
          state_d          = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status_i.single) begin
          cmd_o.single_out = 1'b1;
          state_d          = S_IDLE;
        end else if (status_i.found) begin
          cmd_o.seg_latch = 1'b1;
          state_d         = S_MULT;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      S_MULT: begin
        if (status_i.zero_width) begin
          cmd_o.zero_out = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.mult = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd_o.final_out = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/pli_datapath.sv -----
// ----------------------------------------------------------------------------
// pli_datapath
// Breakpoint memory, segment search compare, magnitude multiply, restoring
// divider and saturating output stage of the interpolator.
// ----------------------------------------------------------------------------
module pli_datapath
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_item_t           in_item_i,
  input  logic               cfg_write_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  output result_t            result_o,
  output logic               result_valid_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;

  logic [COUNT_W-1:0] point_count_q;
  in_item_t           item_q;
  logic [2*Q_W-1:0]   mem_q [MAX_POINTS];
  logic [2*Q_W-1:0]   rd_q, prev_q;
  logic [CW-1:0]      addr_q, addr_d;
  logic [AW-1:0]      raddr;
  logic [NW-1:0]      pc_ext, n_eff, addr_ext;
  logic [IW-1:0]      slot_ext;
  logic               slot_ok;

  logic signed [Q_W-1:0] cur_x, prev_x, prev_y, cur_y;
  logic signed [Q_W:0]   dx, dy, dq, ndx, ndy, ndq;
  logic [Q_W-1:0]        mag_dx_q, mag_dy_q, mag_dq_q;
  logic                  neg_q, zero_q;
  logic signed [Q_W-1:0] y0_q;

  logic [2*Q_W-1:0] quo_q;
  logic [Q_W-1:0]   rem_q;
  logic [5:0]       cnt_q;
  logic [Q_W:0]     trial;
  logic             take;

  logic               big_sat;
  logic signed [36:0] sq, sum;
  logic               sum_sat;
  logic signed [Q_W-1:0] final_y;
  logic [STATUS_W-1:0]   final_st;

  result_t result_q, result_d;
  logic    result_valid_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= COUNT_W'(1);
    end else if (cfg_write_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    pc_ext = NW'(point_count_q);
    if (pc_ext == '0) begin
      n_eff = NW'(1);
    end else if (pc_ext > NW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = pc_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // breakpoint memory, one {x, y} entry per slot
  assign slot_ext = IW'(item_q.point_index);
  assign slot_ok  = (slot_ext < IW'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write && slot_ok) begin
      mem_q[slot_ext[AW-1:0]] <= {item_q.x_value, item_q.y_value};
    end
  end

  assign raddr  = cmd_i.read_first ? '0 : addr_q[AW-1:0];
  assign addr_d = cmd_i.read_first ? CW'(1) : addr_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_first || cmd_i.search_step) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.read_first || cmd_i.search_step) begin
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_step) begin
      prev_q <= rd_q;
    end
  end

  // rd_q holds entry addr_q - 1
  assign addr_ext = NW'(addr_q);
  assign cur_x    = $signed(rd_q[2*Q_W-1:Q_W]);
  assign cur_y    = $signed(rd_q[Q_W-1:0]);
  assign prev_x   = $signed(prev_q[2*Q_W-1:Q_W]);
  assign prev_y   = $signed(prev_q[Q_W-1:0]);

  assign status_o.is_write   = (item_q.opcode == OP_WRITE);
  assign status_o.single     = (n_eff == NW'(1));
  assign status_o.found      = (addr_ext >= NW'(2)) &&
                               ((cur_x >= item_q.x_value) || (addr_ext == n_eff));
  assign status_o.zero_width = zero_q;
  assign status_o.div_last   = &cnt_q;

  // segment differences
  assign dx  = {cur_x[Q_W-1], cur_x} - {prev_x[Q_W-1], prev_x};
  assign dy  = {cur_y[Q_W-1], cur_y} - {prev_y[Q_W-1], prev_y};
  assign dq  = {item_q.x_value[Q_W-1], item_q.x_value} - {prev_x[Q_W-1], prev_x};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ndq = -dq;

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_latch) begin
      mag_dx_q <= dx[Q_W] ? ndx[Q_W-1:0] : dx[Q_W-1:0];
      mag_dy_q <= dy[Q_W] ? ndy[Q_W-1:0] : dy[Q_W-1:0];
      mag_dq_q <= dq[Q_W] ? ndq[Q_W-1:0] : dq[Q_W-1:0];
      neg_q    <= (dy[Q_W] ^ dq[Q_W]) ^ dx[Q_W];
      zero_q   <= (dx == '0);
      y0_q     <= prev_y;
    end
  end

  // multiply, then restoring divide one quotient bit per cycle
  assign trial = {rem_q, quo_q[2*Q_W-1]};
  assign take  = (trial >= {1'b0, mag_dx_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      quo_q <= mag_dy_q * mag_dq_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[2*Q_W-2:0], take};
      rem_q <= take ? Q_W'(trial - {1'b0, mag_dx_q}) : trial[Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mult) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  // signed sum and saturation
  assign big_sat = (quo_q > 64'h0000_0004_0000_0000);
  assign sq      = neg_q ? -$signed({1'b0, quo_q[35:0]}) : $signed({1'b0, quo_q[35:0]});
  assign sum     = {{5{y0_q[Q_W-1]}}, y0_q} + sq;
  assign sum_sat = !((&sum[36:31]) || !(|sum[36:31]));

  always_comb begin
    final_y  = sum[Q_W-1:0];
    final_st = ST_OK;
    if (big_sat) begin
      final_y  = neg_q ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      final_st = ST_SATURATED;
    end else if (sum_sat) begin
      final_y  = sum[36] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      final_st = ST_SATURATED;
    end
  end

  always_comb begin
    result_d = result_q;
    if (cmd_i.write_out) begin
      result_d.y_result = '0;
      result_d.status   = ST_OK;
    end else if (cmd_i.single_out) begin
      result_d.y_result = cur_y;
      result_d.status   = ST_OK;
    end else if (cmd_i.zero_out) begin
      result_d.y_result = y0_q;
      result_d.status   = ST_ZERO_WIDTH;
    end else if (cmd_i.final_out) begin
      result_d.y_result = final_y;
      result_d.status   = final_st;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.write_out | cmd_i.single_out |
                        cmd_i.zero_out | cmd_i.final_out;
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

endmodule

// ----- rtl/piecewise_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with linear interpolation of signed Q16.16 values.
//
//   channel   handshake                    payload
//   command   start_i, busy_o              in_item_i
//   result    result_valid_o (strobe)      result_o
//   config    cfg_valid_i, cfg_ready_o     cfg_wdata_i (point_count)
//
// A write transaction stores its breakpoint in the DISPATCH state and its result
// comes from the result register. A query walks the segment search with one
// breakpoint memory read per search step, then a multiply and a 64-step restoring
// divide; a single-point table or a zero-width segment skips multiply and divide.
// busy_o stays high until the result strobe; the receiver cannot stall.
// Reset sets point_count to 1; the breakpoint memory is not cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  in_item_t           in_item_i,
  output logic               result_valid_o,
  output result_t            result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  pli_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  pli_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_item_i      (in_item_i),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// ----- tb/tb_piecewise_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Self-checking testbench for the breakpoint table interpolator. Loads
// breakpoint tables of several sizes and shapes (ascending, flat runs,
// unordered, extreme values), sweeps point_count over its full range, and
// checks every result strobe against an in-bench interpolation model:
// segment search, truncating Q16.16 divide, saturation and zero-width flags.
// Commands go out in random bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator
  import pli_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PTS        = 64;
  localparam int unsigned ITEM_TARGET    = 1600;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic        OP_QUERY       = ~OP_WRITE;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum int unsigned {
    SHAPE_ASCENDING,
    SHAPE_FLAT_RUNS,
    SHAPE_UNORDERED,
    SHAPE_EXTREME
  } table_shape_e;

  class interp_scoreboard;
    logic signed [Q_W-1:0] bp_x [MAX_PTS];
    logic signed [Q_W-1:0] bp_y [MAX_PTS];
    int unsigned           active_points;
    result_t               pending_results [$];
    int unsigned           mismatches;
    int unsigned           writes_seen;
    int unsigned           queries_seen;
    int unsigned           zero_width_seen;
    int unsigned           saturated_seen;

    function new();
      active_points   = 1;
      mismatches      = 0;
      writes_seen     = 0;
      queries_seen    = 0;
      zero_width_seen = 0;
      saturated_seen  = 0;
    endfunction

    function void set_point_count(logic [COUNT_W-1:0] value);
      if (value == 0) begin
        active_points = 1;
      end else if (value > MAX_PTS) begin
        active_points = MAX_PTS;
      end else begin
        active_points = 32'(value);
      end
    endfunction

    function bit [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function result_t interpolate(logic signed [Q_W-1:0] q);
      result_t     r;
      int unsigned seg;
      int unsigned i;
      bit          found;
      bit          neg;
      longint      x0, x1, y0, y1, dx, dy, dq, sum;
      bit [63:0]   quo;
      r        = '0;
      r.status = ST_OK;
      if (active_points == 1) begin
        r.y_result = bp_y[0];
        return r;
      end
      seg   = active_points - 1;
      found = 1'b0;
      for (i = 1; i < active_points; i++) begin
        if (!found && bp_x[i] >= q) begin
          seg   = i;
          found = 1'b1;
        end
      end
      x0 = longint'(bp_x[seg-1]);
      x1 = longint'(bp_x[seg]);
      y0 = longint'(bp_y[seg-1]);
      y1 = longint'(bp_y[seg]);
      dx = x1 - x0;
      if (dx == 0) begin
        r.status   = ST_ZERO_WIDTH;
        r.y_result = y0[Q_W-1:0];
        return r;
      end
      dy  = y1 - y0;
      dq  = longint'(q) - x0;
      neg = ((dy < 0) != (dq < 0)) != (dx < 0);
      if (dy == 0 || dq == 0) begin
        neg = 1'b0;
      end
      quo = (magnitude(dy) * magnitude(dq)) / magnitude(dx);
      if (quo > 64'h4_0000_0000) begin
        r.status   = ST_SATURATED;
        r.y_result = neg ? Q_MIN : Q_MAX;
      end else begin
        sum = y0 + (neg ? -longint'(quo) : longint'(quo));
        if (sum > Q_MAX) begin
          r.status   = ST_SATURATED;
          r.y_result = Q_MAX;
        end else if (sum < Q_MIN) begin
          r.status   = ST_SATURATED;
          r.y_result = Q_MIN;
        end else begin
          r.y_result = sum[Q_W-1:0];
        end
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      result_t r;
      r = '0;
      if (it.opcode == OP_WRITE) begin
        bp_x[it.point_index] = it.x_value;
        bp_y[it.point_index] = it.y_value;
        r.status = ST_OK;
        writes_seen++;
      end else begin
        r = interpolate(it.x_value);
        queries_seen++;
      end
      pending_results = {pending_results, r};
    endfunction

    function void flag(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display({"mismatch %0d (%s): expected y_result=%h status=%0d, ",
                  "got y_result=%h status=%0d"},
                 mismatches, what, want.y_result, want.status, got.y_result, got.status);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        flag("no transaction pending", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (want.status == ST_ZERO_WIDTH) zero_width_seen++;
      if (want.status == ST_SATURATED) saturated_seen++;
      if (got.y_result !== want.y_result) flag("y_result", want, got);
      if (got.status !== want.status) flag("status", want, got);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic               busy_o;
  in_item_t           in_item_i   = '0;
  logic               result_valid_o;
  result_t            result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;

  interp_scoreboard sb = new();

  int unsigned items_sent    = 0;
  int unsigned config_writes = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned burst_left    = 0;
  longint      shadow_x [MAX_PTS];

  piecewise_linear_interpolator #(
    .MAX_POINTS(MAX_PTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .in_item_i     (in_item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (cfg_valid_i && cfg_ready_o) sb.set_point_count(cfg_wdata_i);
      if (start_i && !busy_o) sb.note_item(in_item_i);
      if (result_valid_o || (cfg_valid_i && cfg_ready_o) || (start_i && !busy_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [Q_W-1:0] to_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v[Q_W-1:0];
  endfunction

  function automatic logic signed [Q_W-1:0] pick_edge_value();
    case ($urandom_range(0, 4))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    start_i   <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // bursts of back-to-back commands separated by random gaps
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 140) : $urandom_range(1, 4);
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_write(input int unsigned slot, input logic signed [Q_W-1:0] x,
                            input logic signed [Q_W-1:0] y);
    in_item_t it;
    it.opcode      = OP_WRITE;
    it.point_index = slot[SLOT_W-1:0];
    it.x_value     = x;
    it.y_value     = y;
    shadow_x[slot] = longint'(x);
    pace();
    send_item(it);
  endtask

  task automatic send_query(input logic signed [Q_W-1:0] x);
    in_item_t it;
    it.opcode      = OP_QUERY;
    it.point_index = SLOT_W'($urandom_range(0, MAX_PTS - 1));
    it.x_value     = x;
    it.y_value     = $urandom();
    pace();
    send_item(it);
  endtask

  // wait until every result is back before touching the register
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_point_count(input logic [COUNT_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    config_writes++;
  endtask

  task automatic load_table(input int unsigned n, input table_shape_e shape);
    longint                x;
    int unsigned           step_cap;
    int unsigned           i;
    logic signed [Q_W-1:0] y;
    case ($urandom_range(0, 3))
      0: step_cap = 32'h40;
      1: step_cap = 32'h1_0000;
      2: step_cap = 32'h100_0000;
      default: step_cap = 32'h1000_0000;
    endcase
    x = -(longint'(n) * longint'(step_cap)) / 2 + longint'($urandom_range(0, step_cap));
    for (i = 0; i < n; i++) begin
      case (shape)
        SHAPE_ASCENDING: x = x + $urandom_range(1, step_cap);
        SHAPE_FLAT_RUNS: x = x + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, step_cap));
        SHAPE_UNORDERED: x = longint'($signed($urandom()));
        default:         x = longint'(pick_edge_value());
      endcase
      case ($urandom_range(0, 3))
        0: y = pick_edge_value();
        1: y = $urandom();
        default: y = to_q(longint'($urandom_range(0, 32'h20_0000)) - 32'h10_0000);
      endcase
      send_write(i, to_q(x), y);
    end
  endtask

  function automatic logic signed [Q_W-1:0] pick_query_x(int unsigned n);
    int unsigned i;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: return to_q(shadow_x[i]);
      3, 4, 5: return to_q(shadow_x[i] + longint'($urandom_range(0, 32'h4_0000)) - 32'h2_0000);
      6: return pick_edge_value();
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] choose_point_count();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'(MAX_PTS);
      4: return COUNT_W'($urandom_range(MAX_PTS + 1, (1 << COUNT_W) - 1));
      5, 6, 7: return COUNT_W'($urandom_range(9, MAX_PTS - 1));
      default: return COUNT_W'($urandom_range(2, 8));
    endcase
  endfunction

  initial begin
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] opening_counts [4];
    int unsigned        n_eff;
    int unsigned        phase;
    int unsigned        slot;
    table_shape_e       shape;

    opening_counts = '{7'(MAX_PTS), 7'd0, 7'd127, 7'd1};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single point in use after reset
    send_write(0, '0, Q_MAX);
    send_query(Q_MIN);
    send_write(0, Q_MAX, Q_MIN);
    send_query(Q_MAX);

    // one segment: inside, below, beyond, on the left end
    set_point_count(7'd2);
    send_write(0, '0, '0);
    send_write(1, 32'sh1_0000, 32'sh3_0000);
    send_query(32'sh8000);
    send_query(-32'sh1_0000);
    send_query(32'sh3_0000);
    send_query('0);

    // zero-width segment
    send_write(1, '0, 32'sh5_0000);
    send_query(32'sd5);

    // huge slope saturating both ways
    send_write(1, 32'sd1, Q_MAX);
    send_query(Q_MAX);
    send_query(Q_MIN);

    // full-range segment
    send_write(0, Q_MIN, Q_MIN);
    send_write(1, Q_MAX, Q_MAX);
    send_query('0);

    // sum just past the upper bound
    send_write(0, '0, Q_MAX - 1);
    send_write(1, 32'sd2, Q_MAX);
    send_query(32'sd4);

    // descending x
    send_write(0, 32'sd100, -32'sh4_0000);
    send_query(32'sd50);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      count = (phase < 4) ? opening_counts[phase] : choose_point_count();
      set_point_count(count);
      n_eff = (count == 0) ? 1 : ((count > MAX_PTS) ? MAX_PTS : 32'(count));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: shape = SHAPE_ASCENDING;
        6, 7: shape = SHAPE_FLAT_RUNS;
        8: shape = SHAPE_UNORDERED;
        default: shape = SHAPE_EXTREME;
      endcase
      load_table(n_eff, shape);
      repeat ($urandom_range(15, 35)) begin
        if ($urandom_range(0, 4) == 0) begin
          slot = $urandom_range(0, MAX_PTS - 1);
          send_write(slot,
                     $urandom_range(0, 1) ? to_q(shadow_x[slot] + $urandom_range(0, 32'h2_0000))
                                          : $urandom(),
                     $urandom());
        end else begin
          send_query(pick_query_x(n_eff));
        end
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("covered %0d transactions: %0d breakpoint writes, %0d queries",
             items_sent, sb.writes_seen, sb.queries_seen);
    $display("point_count writes: %0d, zero-width hits: %0d, saturated: %0d, mismatches: %0d",
             config_writes, sb.zero_width_seen, sb.saturated_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
